// File: hw/rtl/angle_frame_packer_checksum_macros.svh
// Assertion macros shared by the frame packer RTL.
// IMPL checks in the same cycle, NEXT checks in the cycle after.
`ifndef ANGLE_FRAME_PACKER_CHECKSUM_MACROS_SVH
`define ANGLE_FRAME_PACKER_CHECKSUM_MACROS_SVH
`ifndef SYNTH
`define AFPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("afpc assertion failed");
`define AFPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("afpc assertion failed");
`else
`define AFPC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AFPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/afpc_pkg.sv
`timescale 1ns / 1ps
package afpc_pkg;

   // frame layout
   localparam int PAYLOAD_LEN = 17;
   localparam int HDR_LEN     = 4;
   localparam int VALS_LEN    = 17;
   localparam int BODY_LEN    = HDR_LEN + PAYLOAD_LEN;
   localparam int FRAME_LEN   = BODY_LEN + 2;
   localparam int IDX_W       = $clog2(FRAME_LEN);
   localparam int SCALE       = 1000;

   // positions inside the frame
   localparam logic [IDX_W-1:0] IDX_HEAD  = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_DEST  = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_ID    = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_LEN   = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_ZERO  = IDX_W'(HDR_LEN);
   localparam logic [IDX_W-1:0] IDX_WORDS = IDX_W'(HDR_LEN + 1);
   localparam logic [IDX_W-1:0] IDX_PAD   = IDX_W'(HDR_LEN + VALS_LEN);
   localparam logic [IDX_W-1:0] IDX_SUM   = IDX_W'(BODY_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);
   localparam logic [7:0]       LEN_BYTE  = 8'(PAYLOAD_LEN);

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      CSR_HEAD_BYTE = 2'd0,
      CSR_DEST_ADDR = 2'd1,
      CSR_FRAME_ID  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] dest_addr;
      logic [7:0] frame_id;
   } cfg_type;

   // first member is the top of the vector: yaw ends up in the low bytes
   typedef struct packed {
      logic [31:0] team_val;
      logic [31:0] fire_val;
      logic [31:0] pitch_val;
      logic [31:0] yaw_val;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hw/rtl/afpc_front.sv
`timescale 1ns / 1ps
`include "angle_frame_packer_checksum_macros.svh"
module afpc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [31:0]      req_yaw_angle,
   input  logic signed [31:0]      req_pitch_angle,
   input  logic signed [31:0]      req_fire_level,
   input  logic [7:0]              req_team_color,
   input  afpc_pkg::q_status_type  q_status,
   output logic                    push,
   output afpc_pkg::entry_type     push_data
);

   typedef enum logic {
      F_IDLE,
      F_SCALE
   } front_state_type;

   localparam logic [1:0] STEP_YAW   = 2'd0;
   localparam logic [1:0] STEP_PITCH = 2'd1;
   localparam logic [1:0] STEP_FIRE  = 2'd2;
   localparam logic [1:0] STEP_PUSH  = 2'd3;

   front_state_type    state_ff;
   logic [1:0]         step_ff;
   logic signed [31:0] yaw_ff;
   logic signed [31:0] pitch_ff;
   logic signed [31:0] fire_ff;
   logic [7:0]         team_ff;
   logic signed [42:0] prod_ff;
   logic signed [42:0] prod_in;
   logic [31:0]        yaw_val_ff;
   logic [31:0]        pitch_val_ff;
   logic signed [31:0] mul_sel;
   logic [42:0]        biased;
   logic [31:0]        scaled;

   // one shared constant multiplier, one value per cycle
   always_comb begin
      unique case (step_ff)
         STEP_YAW:   mul_sel = yaw_ff;
         STEP_PITCH: mul_sel = pitch_ff;
         default:    mul_sel = fire_ff;
      endcase
      prod_in = $signed({{11{mul_sel[31]}}, mul_sel}) * 43'(afpc_pkg::SCALE);
   end

   // divide by 65536 toward zero: bias negatives before the shift
   assign biased = prod_ff + (prod_ff[42] ? 43'd65535 : 43'd0);
   assign scaled = {{5{biased[42]}}, biased[42:16]};

   assign busy = (state_ff != F_IDLE);
   assign push = (state_ff == F_SCALE) && (step_ff == STEP_PUSH) && !q_status.full;

   always_comb begin
      push_data.team_val  = 32'(team_ff) * 32'(afpc_pkg::SCALE);
      push_data.fire_val  = scaled;
      push_data.pitch_val = pitch_val_ff;
      push_data.yaw_val   = yaw_val_ff;
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (step_ff == STEP_PITCH) begin
         yaw_val_ff <= scaled;
      end
      if (step_ff == STEP_FIRE) begin
         pitch_val_ff <= scaled;
      end
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= STEP_YAW;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  yaw_ff   <= req_yaw_angle;
                  pitch_ff <= req_pitch_angle;
                  fire_ff  <= req_fire_level;
                  team_ff  <= req_team_color;
                  step_ff  <= STEP_YAW;
                  state_ff <= F_SCALE;
               end
            end
            F_SCALE: begin
               if (step_ff != STEP_PUSH) begin
                  step_ff <= step_ff + 2'd1;
               end else if (!q_status.full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   `AFPC_ASSERT_NEXT(a_front_busy_after_start, clock, reset, start && !busy, busy && step_ff == STEP_YAW)

endmodule

// File: hw/rtl/afpc_queue.sv
`timescale 1ns / 1ps
`include "angle_frame_packer_checksum_macros.svh"
module afpc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  afpc_pkg::entry_type    push_data,
   input  logic                   pop,
   output afpc_pkg::entry_type    head,
   output afpc_pkg::q_status_type status
);

   afpc_pkg::entry_type              mem_ff [afpc_pkg::QDEPTH];
   logic [afpc_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [afpc_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [afpc_pkg::QCNT_W-1:0]      count_ff;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == afpc_pkg::QCNT_W'(afpc_pkg::QDEPTH));
   assign status.empty = (count_ff == '0);

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == afpc_pkg::QPTR_W'(afpc_pkg::QDEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == afpc_pkg::QPTR_W'(afpc_pkg::QDEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `AFPC_ASSERT_IMPL(a_queue_no_overflow, clock, reset, push, !status.full)
   `AFPC_ASSERT_IMPL(a_queue_no_underflow, clock, reset, pop, !status.empty)

endmodule

// File: hw/rtl/afpc_back.sv
`timescale 1ns / 1ps
`include "angle_frame_packer_checksum_macros.svh"
module afpc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  afpc_pkg::cfg_type       cfg,
   input  afpc_pkg::q_status_type  q_status,
   input  afpc_pkg::entry_type     head,
   output logic                    pop,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_last_byte
);

   logic                            active_ff;
   logic [afpc_pkg::IDX_W-1:0]      idx_ff;
   afpc_pkg::entry_type             cur_ff;
   logic [7:0]                      sum_ff;
   logic [7:0]                      sum_in;
   logic [7:0]                      add_ff;
   logic [7:0]                      add_in;
   logic                            rsp_strobe_ff;
   logic [7:0]                      rsp_frame_byte_ff;
   logic                            rsp_last_byte_ff;
   logic [afpc_pkg::IDX_W-1:0]      word_off;
   logic [127:0]                    word_vec;
   logic [7:0]                      byte_sel;
   logic                            at_last;

   assign at_last = (idx_ff == afpc_pkg::IDX_LAST);
   assign pop     = !q_status.empty && (!active_ff || at_last);

   // byte for the current frame position
   assign word_off = idx_ff - afpc_pkg::IDX_WORDS;
   assign word_vec = cur_ff;
   always_comb begin
      priority if (idx_ff == afpc_pkg::IDX_HEAD) begin
         byte_sel = cfg.head_byte;
      end else if (idx_ff == afpc_pkg::IDX_DEST) begin
         byte_sel = cfg.dest_addr;
      end else if (idx_ff == afpc_pkg::IDX_ID) begin
         byte_sel = cfg.frame_id;
      end else if (idx_ff == afpc_pkg::IDX_LEN) begin
         byte_sel = afpc_pkg::LEN_BYTE;
      end else if (idx_ff == afpc_pkg::IDX_ZERO) begin
         byte_sel = 8'd0;
      end else if (idx_ff < afpc_pkg::IDX_PAD) begin
         byte_sel = word_vec[{word_off[3:0], 3'b000} +: 8];
      end else if (idx_ff < afpc_pkg::IDX_SUM) begin
         byte_sel = 8'd0;
      end else if (idx_ff == afpc_pkg::IDX_SUM) begin
         byte_sel = sum_ff;
      end else begin
         byte_sel = add_ff;
      end
   end

   // running sum and sum of sums over the body
   always_comb begin
      sum_in = sum_ff;
      if (idx_ff < afpc_pkg::IDX_SUM) begin
         sum_in = sum_ff + byte_sel;
      end
      add_in = add_ff;
      if (idx_ff < afpc_pkg::IDX_SUM) begin
         add_in = add_ff + sum_in;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      rsp_frame_byte_ff <= byte_sel;
      if (pop) begin
         cur_ff <= head;
         sum_ff <= 8'd0;
         add_ff <= 8'd0;
      end else if (active_ff) begin
         sum_ff <= sum_in;
         add_ff <= add_in;
      end
      if (reset) begin
         active_ff        <= 1'b0;
         idx_ff           <= '0;
         rsp_strobe_ff    <= 1'b0;
         rsp_last_byte_ff <= 1'b0;
      end else begin
         rsp_strobe_ff    <= active_ff;
         rsp_last_byte_ff <= active_ff && at_last;
         if (pop) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
         end else if (active_ff) begin
            if (at_last) begin
               active_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;

   `AFPC_ASSERT_NEXT(a_back_last_marked, clock, reset, active_ff && at_last, rsp_strobe_ff && rsp_last_byte_ff)
   `AFPC_ASSERT_NEXT(a_back_reload_at_zero, clock, reset, pop, active_ff && idx_ff == afpc_pkg::IDX_HEAD)

endmodule

// File: hw/rtl/angle_frame_packer_checksum.sv
`timescale 1ns / 1ps
// Each item gives one frame of 23 bytes, sent one byte per cycle; frames follow
// back to back while items wait in the queue. The byte serializer sets the rate.
// The front takes a new item while up to two scaled items wait for the serializer.
// Reset: synchronous, active high; clears control state and sets head_byte to 0xFF.
// Results cannot be stalled by the receiver.
module angle_frame_packer_checksum (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_yaw_angle,
   input  logic signed [31:0] req_pitch_angle,
   input  logic signed [31:0] req_fire_level,
   input  logic [7:0]         req_team_color,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_write_data
);

   afpc_pkg::cfg_type      cfg_ff;
   afpc_pkg::q_status_type q_status;
   afpc_pkg::entry_type    push_data;
   afpc_pkg::entry_type    q_head;
   logic                   push;
   logic                   pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte <= 8'hFF;
         cfg_ff.dest_addr <= 8'd0;
         cfg_ff.frame_id  <= 8'd0;
      end else if (csr_write_enable) begin
         unique case (afpc_pkg::csr_index_type'(csr_index))
            afpc_pkg::CSR_HEAD_BYTE: cfg_ff.head_byte <= csr_write_data;
            afpc_pkg::CSR_DEST_ADDR: cfg_ff.dest_addr <= csr_write_data;
            afpc_pkg::CSR_FRAME_ID:  cfg_ff.frame_id  <= csr_write_data;
            default: ;
         endcase
      end
   end

   afpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_yaw_angle   (req_yaw_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_fire_level  (req_fire_level),
      .req_team_color  (req_team_color),
      .q_status        (q_status),
      .push            (push),
      .push_data       (push_data)
   );

   afpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .status    (q_status)
   );

   afpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .head           (q_head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam longint     Q16_ONE        = 64'sd65536;
   localparam longint     INT32_MAX      = 64'sd2147483647;
   localparam longint     INT32_MIN      = -64'sd2147483648;
   localparam int         DRAIN_SLACK    = 12;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         MAX_PRINTS     = 40;
   localparam int         RANDOM_PHASES  = 8;
   localparam int         PHASE_ITEMS    = 48;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } frame_beat_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               start            = 1'b0;
   logic               busy;
   logic signed [31:0] req_yaw_angle    = '0;
   logic signed [31:0] req_pitch_angle  = '0;
   logic signed [31:0] req_fire_level   = '0;
   logic [7:0]         req_team_color   = '0;
   logic               rsp_strobe;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_last_byte;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index        = '0;
   logic [7:0]         csr_write_data   = '0;

   // register shadows, reset values
   logic [7:0] cfg_head = 8'hFF;
   logic [7:0] cfg_dest = 8'h00;
   logic [7:0] cfg_id   = 8'h00;

   frame_beat_type frame_bytes_due[$];
   int             mismatch_count = 0;
   int             idle_cycles    = 0;
   bit             sender_gaps    = 1'b1;

   angle_frame_packer_checksum dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_yaw_angle    (req_yaw_angle),
      .req_pitch_angle  (req_pitch_angle),
      .req_fire_level   (req_fire_level),
      .req_team_color   (req_team_color),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Q16.16 times 1000, truncated toward zero, clamped to int32
   function automatic logic [31:0] scale_angle(logic signed [31:0] raw);
      longint prod;
      longint quo;
      prod = longint'(raw) * afpc_pkg::SCALE;
      quo  = prod / Q16_ONE;
      if (quo > INT32_MAX) quo = INT32_MAX;
      if (quo < INT32_MIN) quo = INT32_MIN;
      return quo[31:0];
   endfunction

   // build the whole frame for one item and queue its bytes
   task automatic predict_frame(input logic signed [31:0] yaw, input logic signed [31:0] pitch,
                                input logic signed [31:0] fire, input logic [7:0] team);
      logic [7:0]     frame[afpc_pkg::FRAME_LEN];
      logic [7:0]     vals[afpc_pkg::VALS_LEN];
      logic [31:0]    words[4];
      logic [7:0]     run_sum;
      logic [7:0]     run_add;
      frame_beat_type beat;
      words[0] = scale_angle(yaw);
      words[1] = scale_angle(pitch);
      words[2] = scale_angle(fire);
      words[3] = 32'(team) * 32'(afpc_pkg::SCALE);
      vals[0]  = 8'h00;
      for (int w = 0; w < 4; w++)
         for (int b = 0; b < 4; b++)
            vals[1 + 4 * w + b] = words[w][8 * b +: 8];
      frame[0] = cfg_head;
      frame[1] = cfg_dest;
      frame[2] = cfg_id;
      frame[3] = afpc_pkg::LEN_BYTE;
      for (int i = 0; i < afpc_pkg::PAYLOAD_LEN; i++)
         frame[afpc_pkg::HDR_LEN + i] = (i < afpc_pkg::VALS_LEN) ? vals[i] : 8'h00;
      run_sum = '0;
      run_add = '0;
      for (int i = 0; i < afpc_pkg::BODY_LEN; i++) begin
         run_sum += frame[i];
         run_add += run_sum;
      end
      frame[afpc_pkg::BODY_LEN]     = run_sum;
      frame[afpc_pkg::BODY_LEN + 1] = run_add;
      for (int i = 0; i < afpc_pkg::FRAME_LEN; i++) begin
         beat.data    = frame[i];
         beat.is_last = (i == afpc_pkg::FRAME_LEN - 1);
         frame_bytes_due.push_back(beat);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // random sender gap; time always advances when start is lowered
   task automatic maybe_pause();
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // present one item, hold until the transfer, then queue its frame
   task automatic send_angles(input logic signed [31:0] yaw, input logic signed [31:0] pitch,
                              input logic signed [31:0] fire, input logic [7:0] team);
      req_yaw_angle   <= yaw;
      req_pitch_angle <= pitch;
      req_fire_level  <= fire;
      req_team_color  <= team;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      predict_frame(yaw, pitch, fire, team);
      maybe_pause();
   endtask

   // stop sending and let every queued frame come out
   task automatic wait_drain();
      start <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // enable stays high; csr_done lowers it after the last write
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         afpc_pkg::CSR_HEAD_BYTE: cfg_head = data;
         afpc_pkg::CSR_DEST_ADDR: cfg_dest = data;
         afpc_pkg::CSR_FRAME_ID:  cfg_id   = data;
         default: ;
      endcase
   endtask

   task automatic csr_done();
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_csr(input logic [7:0] head, input logic [7:0] dest,
                              input logic [7:0] id);
      write_csr(afpc_pkg::CSR_HEAD_BYTE, head);
      write_csr(afpc_pkg::CSR_DEST_ADDR, dest);
      write_csr(afpc_pkg::CSR_FRAME_ID, id);
      csr_done();
   endtask

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1: return 32'($signed($urandom_range(0, 400)) - 200);
         2: return 32'($signed($urandom_range(0, 360 << 16)) - (180 << 16));
         3: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // frames with the register values left by reset
   task automatic test_reset_defaults();
      send_angles(32'sh0001_0000, 32'sh0002_8000, 32'sh0000_0000, 8'd1);
      send_angles(-32'sh0001_0000, 32'sh0000_4000, 32'sh0001_0000, 8'd2);
   endtask

   // a write to the unused index must not touch any register
   task automatic test_unused_index();
      wait_drain();
      write_csr(CSR_UNUSED, 8'h5A);
      csr_done();
      send_angles(32'sh0000_1234, -32'sh0000_1234, 32'sh7FFF_0000, 8'd77);
   endtask

   // field extremes, truncation toward zero and checksum wrap
   task automatic test_field_extremes();
      wait_drain();
      program_csr(8'h00, 8'h00, 8'h00);
      send_angles(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 8'd0);
      send_angles(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 8'd255);
      send_angles(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 8'd1);
      send_angles(32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 8'd128);
      // 65 scales to just under one, 66 to just over
      send_angles(32'sd65, 32'sd66, -32'sd66, 8'd2);
      send_angles(-32'sd65, -32'sd1, 32'sd65535, 8'd3);
      send_angles(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 8'hAA);
      send_angles(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 8'h55);
      wait_drain();
      program_csr(8'hFF, 8'hFF, 8'hFF);
      send_angles(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd255);
      send_angles(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 8'd255);
      send_angles(-32'sd1, -32'sd1, -32'sd1, 8'd0);
      send_angles(32'sh00B4_0000, -32'sh00B4_0000, 32'sh0000_0001, 8'd100);
   endtask

   // random frames over several register settings
   task automatic test_random_frames();
      logic [7:0] head;
      logic [7:0] dest;
      logic [7:0] id;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drain();
         head = 8'($urandom);
         dest = 8'($urandom);
         id   = 8'($urandom);
         if (phase == 0) begin
            head = 8'hFF;
            dest = 8'h00;
            id   = 8'hFF;
         end else if (phase == 1) begin
            head = 8'h00;
            dest = 8'hFF;
            id   = 8'h00;
         end
         program_csr(head, dest, id);
         sender_gaps = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // the last phase runs back to back
            if (phase == RANDOM_PHASES - 1)
               sender_gaps = 1'b0;
            else if (k % 16 == 0)
               sender_gaps = ($urandom_range(0, 2) != 0);
            send_angles(rand_angle(), rand_angle(), rand_angle(), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // compare each output byte with the oldest queued one
   always @(posedge clock) begin : check_frames
      frame_beat_type due;
      if (!reset && rsp_strobe) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch("unexpected frame byte", 32'(rsp_frame_byte), 32'h0);
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== due.data)
               report_mismatch("frame_byte", 32'(rsp_frame_byte), 32'(due.data));
            if (rsp_last_byte !== due.is_last)
               report_mismatch("last_byte", 32'(rsp_last_byte), 32'(due.is_last));
         end
      end
   end

   // no transfer on either side for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_unused_index();
      test_field_extremes();
      test_random_frames();
      wait_drain();
      if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d bytes outstanding", mismatch_count,
                  frame_bytes_due.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
